### rtl/core/npi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npi_pkg
// Shared types, codes and helpers of the Neville polynomial interpolator.
// ----------------------------------------------------------------------------
package npi_pkg;

  localparam int unsigned DefMaxPoints = 16;
  localparam int unsigned CountWidth   = 5;
  localparam int unsigned WordWidth    = 32;

  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_DUP = 2'd1;
  localparam logic [1:0] STATUS_SAT = 2'd2;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [3:0]         point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] query_x;
  } npi_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } npi_out_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } npi_sat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_RD,
    ST_DIFF,
    ST_MUL1,
    ST_MUL2,
    ST_SUB,
    ST_DIV,
    ST_FIN_RD,
    ST_FIN
  } npi_state_e;

  function automatic npi_sat_t sat_diff(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] d;
    npi_sat_t r;
    d = 33'(a) - 33'(b);
    r.sat = 1'b0;
    r.val = d[31:0];
    if (d[32] != d[31]) begin
      r.sat = 1'b1;
      r.val = d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

### rtl/core/npi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npi_div
// Restoring unsigned divider, 64-bit dividend by 32-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module npi_div
  import npi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [31:0] dsr_q, dsr_d;
  logic [32:0] rem_sh;
  logic        ge;

  always_comb begin
    rem_sh = {rem_q[31:0], quo_q[63]};
    ge     = rem_sh >= {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
      quo_d = {quo_q[62:0], ge};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without work");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");

endmodule

### rtl/core/neville_polynomial_interpolator.sv
`timescale 1ns / 1ps
// Timing: each recurrence step of a query waits on the shared divider, which
// produces one quotient bit per cycle.
// Throughput: one transaction at a time; loads follow back to back while no
// held result is stalled at the output.
// Reset: point_count returns to 1, control idles; tables are undefined.
// ----------------------------------------------------------------------------
// neville_polynomial_interpolator
// Point table and Neville recurrence sequencer with one shared multiplier
// and one shared iterative divider.
// ----------------------------------------------------------------------------
module neville_polynomial_interpolator
  import npi_pkg::*;
#(
  parameter int unsigned MAX_POINTS = DefMaxPoints
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CountWidth-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  npi_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output npi_out_t              out_data_o
);

  localparam int unsigned IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned NW = IW + 1;

  npi_state_e state_q, state_d;

  logic [CountWidth-1:0] count_q;
  logic [NW-1:0]         n_q, n_d, n_cfg;
  logic [NW-1:0]         i_q, i_d, k_q, k_d, c_q, c_d;
  logic                  sat_q, sat_d;
  logic                  ovalid_q, ovalid_d;
  npi_out_t              out_q, out_d;
  logic signed [31:0]    qx_q;

  logic signed [31:0] abs_mem [MAX_POINTS];
  logic signed [31:0] ord_mem [MAX_POINTS];
  logic signed [31:0] scr_mem [MAX_POINTS];

  logic signed [31:0] xa_q, xb_q, pa_q, pb_q, ord_q;
  logic signed [31:0] den_q, dfar_q, dnear_q;
  logic signed [63:0] ma_q, mb_q;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  npi_sat_t           s_den, s_far, s_near;

  logic               in_acc;
  logic [IW-1:0]      ra_addr, rb_addr, pb_addr;
  logic               scr_we;
  logic [IW-1:0]      scr_waddr;
  logic signed [31:0] scr_wdata;

  logic signed [64:0] num;
  logic [63:0]        un;
  logic [31:0]        ud;
  logic               neg_q, neg_d;
  logic               div_start, div_busy, div_done;
  logic [63:0]        div_quo;
  logic signed [31:0] qres;
  logic               qsat;

  assign n_cfg = (count_q == '0) ? NW'(1) :
                 (32'(count_q) > 32'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(count_q);

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !((state_q == ST_IDLE) && (!ovalid_q || !out_stall_i));
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

  assign ra_addr = IW'(i_q);
  assign rb_addr = IW'(i_q + k_q);
  assign pb_addr = IW'(i_q + NW'(1));

  assign s_den  = sat_diff(xa_q, xb_q);
  assign s_far  = sat_diff(qx_q, xb_q);
  assign s_near = sat_diff(qx_q, xa_q);

  assign mul_a = (state_q == ST_MUL2) ? dnear_q : dfar_q;
  assign mul_b = (state_q == ST_MUL2) ? pb_q : pa_q;
  assign mul_p = mul_a * mul_b;

  assign num = {ma_q[63], ma_q} - {mb_q[63], mb_q};
  assign un  = num[64] ? 64'(-num) : num[63:0];
  assign ud  = den_q[31] ? 32'(-den_q) : den_q;

  always_comb begin
    qsat = 1'b0;
    if (neg_q) begin
      if (div_quo > 64'h8000_0000) begin
        qsat = 1'b1;
        qres = 32'sh8000_0000;
      end else begin
        qres = 32'(-div_quo);
      end
    end else begin
      if (div_quo > 64'h7fff_ffff) begin
        qsat = 1'b1;
        qres = 32'sh7fff_ffff;
      end else begin
        qres = div_quo[31:0];
      end
    end
  end

  npi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (un),
    .divisor_i  (ud),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    i_d       = i_q;
    k_d       = k_q;
    c_d       = c_q;
    sat_d     = sat_q;
    neg_d     = neg_q;
    ovalid_d  = ovalid_q && out_stall_i;
    out_d     = out_q;
    div_start = 1'b0;
    scr_we    = 1'b0;
    scr_waddr = IW'(c_q);
    scr_wdata = ord_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_data_i.mode == MODE_QUERY) begin
          n_d     = n_cfg;
          i_d     = '0;
          k_d     = NW'(1);
          c_d     = '0;
          sat_d   = 1'b0;
          state_d = ST_COPY_RD;
        end
      end
      ST_COPY_RD: state_d = ST_COPY_WR;
      ST_COPY_WR: begin
        scr_we = 1'b1;
        if (c_q == n_q - NW'(1)) begin
          state_d = (n_q == NW'(1)) ? ST_FIN_RD : ST_RD;
        end else begin
          c_d     = c_q + NW'(1);
          state_d = ST_COPY_RD;
        end
      end
      ST_RD: state_d = ST_DIFF;
      ST_DIFF: begin
        sat_d = sat_q | s_den.sat | s_far.sat | s_near.sat;
        if (s_den.val == '0) begin
          ovalid_d     = 1'b1;
          out_d.value  = '0;
          out_d.status = STATUS_DUP;
          state_d      = ST_IDLE;
        end else begin
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_SUB;
      ST_SUB: begin
        div_start = 1'b1;
        neg_d     = num[64] != den_q[31];
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          scr_we    = 1'b1;
          scr_waddr = ra_addr;
          scr_wdata = qres;
          sat_d     = sat_q | qsat;
          if ((i_q + k_q + NW'(1)) < n_q) begin
            i_d     = i_q + NW'(1);
            state_d = ST_RD;
          end else if ((k_q + NW'(1)) < n_q) begin
            i_d     = '0;
            k_d     = k_q + NW'(1);
            state_d = ST_RD;
          end else begin
            state_d = ST_FIN_RD;
          end
        end
      end
      ST_FIN_RD: state_d = ST_FIN;
      ST_FIN: begin
        ovalid_d     = 1'b1;
        out_d.value  = pa_q;
        out_d.status = sat_q ? STATUS_SAT : STATUS_OK;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= CountWidth'(1);
      ovalid_q <= 1'b0;
      n_q      <= NW'(1);
      i_q      <= '0;
      k_q      <= NW'(1);
      c_q      <= '0;
      sat_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      n_q      <= n_d;
      i_q      <= i_d;
      k_q      <= k_d;
      c_q      <= c_d;
      sat_q    <= sat_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    neg_q <= neg_d;
    if (in_acc && in_data_i.mode == MODE_QUERY) begin
      qx_q <= in_data_i.query_x;
    end
    if (in_acc && in_data_i.mode == MODE_LOAD &&
        32'(in_data_i.point_index) < 32'(MAX_POINTS)) begin
      abs_mem[IW'(in_data_i.point_index)] <= in_data_i.point_x;
      ord_mem[IW'(in_data_i.point_index)] <= in_data_i.point_y;
    end
    xa_q  <= abs_mem[ra_addr];
    xb_q  <= abs_mem[rb_addr];
    ord_q <= ord_mem[IW'(c_q)];
    if (scr_we) begin
      scr_mem[scr_waddr] <= scr_wdata;
    end
    pa_q <= scr_mem[ra_addr];
    pb_q <= scr_mem[pb_addr];
    if (state_q == ST_DIFF) begin
      den_q   <= s_den.val;
      dfar_q  <= s_far.val;
      dnear_q <= s_near.val;
    end
    if (state_q == ST_MUL1) begin
      ma_q <= mul_p;
    end
    if (state_q == ST_MUL2) begin
      mb_q <= mul_p;
    end
  end

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> state_q == ST_IDLE) else $error("input taken while busy");
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !$past(ovalid_q)) |-> ($past(state_q) == ST_FIN ||
    $past(state_q) == ST_DIFF)) else $error("result without evaluation");
  a_dup_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && out_q.status == STATUS_DUP) |-> out_q.value == '0)
    else $error("duplicate abscissa result not zero");
  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> state_q == ST_DIV) else $error("divider busy outside divide");

endmodule

### sim/neville_polynomial_interpolator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neville_polynomial_interpolator_tb
// Fills the point table, runs directed corner transactions (reset count, count
// extremes, duplicate abscissas, full-scale values), then random load/query
// phases under several point counts with random idling on both channels. Each
// result is checked against a bit-accurate Neville predictor or a fixed value.
// ----------------------------------------------------------------------------
module neville_polynomial_interpolator_tb;
  import npi_pkg::*;

  localparam int unsigned NumPoints = DefMaxPoints;

  typedef struct {
    bit              do_cfg;
    logic [4:0]      cfg;
    npi_in_t         item;
    bit              chk;
    npi_out_t        res;
  } dir_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     cfg_valid_i;
  logic     cfg_ready_o;
  logic [CountWidth-1:0] cfg_data_i;
  logic     in_valid_i;
  logic     in_stall_o;
  npi_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  npi_out_t out_data_o;

  logic signed [31:0] tbl_x [NumPoints];
  logic signed [31:0] tbl_y [NumPoints];
  logic [4:0]         cur_count;
  npi_out_t           pending_res[$];
  int                 errors;
  int                 n_loads;
  int                 n_queries;
  int                 n_dup;
  int                 n_sat;
  bit                 idle_en;
  int                 stall_left;

  dir_row_t dir_rows[14] = '{
    '{1'b0, 5'd0, '{MODE_LOAD, 4'd0, 32'sh0001_0000, 32'sh7fff_ffff, 32'sh0}, 1'b0,
      '{32'sh0, STATUS_OK}},
    '{1'b0, 5'd0, '{MODE_QUERY, 4'd0, 32'sh0, 32'sh0, 32'sh8000_0000}, 1'b1,
      '{32'sh7fff_ffff, STATUS_OK}},
    '{1'b1, 5'd2, '{MODE_LOAD, 4'd1, 32'sh0001_0000, 32'sh8000_0000, 32'sh0}, 1'b0,
      '{32'sh0, STATUS_OK}},
    '{1'b0, 5'd0, '{MODE_QUERY, 4'd0, 32'sh0, 32'sh0, 32'sh0}, 1'b1,
      '{32'sh0, STATUS_DUP}},
    '{1'b0, 5'd0, '{MODE_LOAD, 4'd1, 32'sh8000_0000, 32'sh8000_0000, 32'sh0}, 1'b0,
      '{32'sh0, STATUS_OK}},
    '{1'b0, 5'd0, '{MODE_LOAD, 4'd0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh0}, 1'b0,
      '{32'sh0, STATUS_OK}},
    '{1'b0, 5'd0, '{MODE_QUERY, 4'd0, 32'sh0, 32'sh0, 32'sh7fff_ffff}, 1'b0,
      '{32'sh0, STATUS_OK}},
    '{1'b0, 5'd0, '{MODE_QUERY, 4'd0, 32'sh0, 32'sh0, 32'sh8000_0000}, 1'b0,
      '{32'sh0, STATUS_OK}},
    '{1'b1, 5'd0, '{MODE_QUERY, 4'd0, 32'sh0, 32'sh0, 32'sh0}, 1'b1,
      '{32'sh7fff_ffff, STATUS_OK}},
    '{1'b1, 5'd31, '{MODE_QUERY, 4'd0, 32'sh0, 32'sh0, 32'sh0001_8000}, 1'b0,
      '{32'sh0, STATUS_OK}},
    '{1'b1, 5'd16, '{MODE_LOAD, 4'd0, 32'sh0, 32'sh0, 32'sh0}, 1'b0,
      '{32'sh0, STATUS_OK}},
    '{1'b0, 5'd0, '{MODE_LOAD, 4'd1, 32'sh0001_0000, 32'sh0001_0000, 32'sh0}, 1'b0,
      '{32'sh0, STATUS_OK}},
    '{1'b0, 5'd0, '{MODE_QUERY, 4'd0, 32'sh0, 32'sh0, 32'sh0002_8000}, 1'b0,
      '{32'sh0, STATUS_OK}},
    '{1'b1, 5'd3, '{MODE_QUERY, 4'd0, 32'sh0, 32'sh0, 32'shffff_8000}, 1'b0,
      '{32'sh0, STATUS_OK}}
  };

  neville_polynomial_interpolator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic signed [65:0] clamp_word(input logic signed [65:0] v,
                                                    inout bit sat);
    if (v > 66'sh0_7fff_ffff) begin
      sat = 1'b1;
      return 66'sh0_7fff_ffff;
    end
    if (v < -66'sh0_8000_0000) begin
      sat = 1'b1;
      return -66'sh0_8000_0000;
    end
    return v;
  endfunction

  function automatic npi_out_t neville_eval(logic signed [31:0] q);
    logic signed [65:0] row [NumPoints];
    logic signed [65:0] qw, xi, xk, den, dfar, dnear, num;
    int n;
    bit sat;
    npi_out_t r;
    sat = 1'b0;
    n = (cur_count == 0) ? 1 : (cur_count > NumPoints) ? NumPoints : int'(cur_count);
    qw = q;
    for (int i = 0; i < n; i++) row[i] = tbl_y[i];
    for (int k = 1; k < n; k++) begin
      for (int i = 0; i + k < n; i++) begin
        xi = tbl_x[i];
        xk = tbl_x[i + k];
        den = clamp_word(xi - xk, sat);
        dfar = clamp_word(qw - xk, sat);
        dnear = clamp_word(qw - xi, sat);
        if (den == 0) begin
          r.value = '0;
          r.status = STATUS_DUP;
          return r;
        end
        num = dfar * row[i] - dnear * row[i + 1];
        row[i] = clamp_word(num / den, sat);
      end
    end
    r.value = row[0][31:0];
    r.status = sat ? STATUS_SAT : STATUS_OK;
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_count(logic [4:0] cnt);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= cnt;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_count = cnt;
  endtask

  // Hold valid high across back-to-back transactions; drop it only for a gap.
  task automatic send_item(npi_in_t it, bit chk, npi_out_t res);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (it.mode == MODE_LOAD) begin
      tbl_x[it.point_index] = it.point_x;
      tbl_y[it.point_index] = it.point_y;
      n_loads++;
    end else begin
      pending_res.push_back(chk ? res : neville_eval(it.query_x));
      n_queries++;
    end
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'sh7fff_ffff - $urandom_range(0, 3);
      2: return 32'sh8000_0000 + $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
    endcase
  endfunction

  function automatic npi_in_t rand_item();
    npi_in_t it;
    it.mode = ($urandom_range(0, 9) < 6) ? MODE_LOAD : MODE_QUERY;
    it.point_index = $urandom_range(0, 15);
    it.point_y = rand_word();
    it.query_x = rand_word();
    if ($urandom_range(0, 3) == 0) it.point_x = rand_word();
    else it.point_x = (32'(it.point_index) << 16) + $urandom_range(0, 16'hffff);
    return it;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    npi_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_res.size() == 0) begin
        $error("unexpected result value=%h status=%0d", out_data_o.value, out_data_o.status);
        errors++;
      end else begin
        want = pending_res.pop_front();
        if (want.value !== out_data_o.value) begin
          $error("value: expected %h actual %h", want.value, out_data_o.value);
          errors++;
        end
        if (want.status !== out_data_o.status) begin
          $error("status: expected %0d actual %0d", want.status, out_data_o.status);
          errors++;
        end
        if (want.status == STATUS_DUP) n_dup++;
        if (want.status == STATUS_SAT) n_sat++;
      end
    end
  end

  initial begin
    npi_in_t it;
    npi_out_t none;
    errors = 0;
    n_loads = 0;
    n_queries = 0;
    n_dup = 0;
    n_sat = 0;
    idle_en = 1'b1;
    cur_count = 5'd1;
    none = '0;
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumPoints; i++) begin
      it = '0;
      it.mode = MODE_LOAD;
      it.point_index = 4'(i);
      it.point_x = 32'(i) << 16;
      it.point_y = 32'(i * i) << 14;
      send_item(it, 1'b0, none);
    end

    foreach (dir_rows[r]) begin
      if (dir_rows[r].do_cfg) begin
        in_valid_i <= 1'b0;
        write_count(dir_rows[r].cfg);
      end
      send_item(dir_rows[r].item, dir_rows[r].chk, dir_rows[r].res);
    end

    for (int ph = 0; ph < 12; ph++) begin
      int sel;
      logic [4:0] cnt;
      sel = $urandom_range(0, 19);
      cnt = (sel == 0) ? 5'd16 : (sel == 1) ? 5'd0 : (sel == 2) ? 5'd31 :
            5'($urandom_range(1, 6));
      if (ph >= 9) idle_en = 1'b0;
      in_valid_i <= 1'b0;
      write_count(cnt);
      for (int j = 0; j < 8; j++) send_item(rand_item(), 1'b0, none);
    end
    in_valid_i <= 1'b0;

    wait_drained();
    $display("covered %0d loads and %0d queries (%0d duplicate-abscissa, %0d saturated)",
             n_loads, n_queries, n_dup, n_sat);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
